/* hdl/cff_pkg.sv */
package cff_pkg;

    localparam int VEC_W    = 32;
    localparam int FW       = 32;
    localparam int MUW      = 16;
    localparam int NUW      = FW + 1;
    localparam int PW       = 2 * NUW;
    localparam int MRW      = MUW + FW + 1;
    localparam int MAGW     = 37;
    localparam int SQ_STEPS = 32;
    localparam int LENW     = 33;
    localparam int QW       = 17;
    localparam int REMW     = FW + 16;
    localparam int DW       = REMW + 2;
    localparam int UPW      = QW + 1;
    localparam int UMW      = UPW + FW;
    localparam int Q_AW     = 1;
    localparam int Q_DEPTH  = 1 << Q_AW;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VEC_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_STATIC  = 2'd1,
        MODE_SLIDING = 2'd2
    } t_mode;

    typedef logic [2:0][FW-1:0] t_vec3;

    typedef struct packed {
        t_vec3           f;
        t_vec3           m;
        logic [FW-1:0]   n;
        logic [MUW-1:0]  mu;
        t_mode           mode;
    } t_item;

    typedef struct packed {
        t_vec3                  f;
        t_vec3                  m;
        logic signed [MAGW-1:0] mag;
        t_mode                  mode;
    } t_sq_pay;

    typedef struct packed {
        t_vec3                f;
        logic [LENW-1:0]      len;
        logic signed [FW-1:0] mag;
        logic [2:0]           neg;
        t_mode                mode;
    } t_dv_pay;

    function automatic logic signed [FW-1:0] sat_vec(input logic signed [63:0] x);
        logic signed [63:0] y;
        if (x > SAT_HI) begin
            y = SAT_HI;
        end else if (x < SAT_LO) begin
            y = SAT_LO;
        end else begin
            y = x;
        end
        return y[FW-1:0];
    endfunction

endpackage

/* hdl/cff_front.sv */
module cff_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  cff_pkg::t_vec3              i_force,
    input  cff_pkg::t_vec3              i_up,
    input  cff_pkg::t_vec3              i_vel,
    input  logic [cff_pkg::MUW-1:0]     i_mu_static,
    input  logic [cff_pkg::MUW-1:0]     i_mu_sliding,
    input  logic                        i_grounded,
    output logic                        o_push,
    output cff_pkg::t_item              o_item
);
    import cff_pkg::*;

    logic r1_v, r2_v, r3_v;
    t_vec3 r1_f, r2_f, r3_f;
    logic signed [NUW-1:0] r1_nu [3];
    logic signed [NUW-1:0] r2_nu [3];
    logic signed [PW-1:0]  r1_p [3];
    logic signed [PW-1:0]  r3_q [3];
    logic signed [FW-1:0]  r2_n, r3_n;
    logic r1_rest, r2_rest, r3_rest;
    logic r1_gnd, r2_gnd, r3_gnd;
    logic [MUW-1:0] r1_mus, r2_mus, r3_mus;
    logic [MUW-1:0] r1_muk, r2_muk, r3_muk;

    logic signed [NUW-1:0] n_nu [3];
    logic signed [PW-1:0]  n_p [3];
    logic signed [PW-1:0]  n_sum;
    logic signed [FW-1:0]  n_n;
    logic signed [PW-1:0]  n_q [3];
    logic signed [PW-1:0]  m_full [3];
    logic                  m_nz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_nu[i] = -$signed({i_up[i][FW-1], i_up[i]});
            n_p[i]  = $signed(i_force[i]) * n_nu[i];
        end
        n_sum = (r1_p[0] >>> 16) + (r1_p[1] >>> 16) + (r1_p[2] >>> 16);
        n_n   = sat_vec(n_sum[63:0]);
        for (int i = 0; i < 3; i++) begin
            n_q[i] = r2_nu[i] * r2_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_f    <= i_force;
        r1_nu   <= n_nu;
        r1_p    <= n_p;
        r1_rest <= (i_vel == '0);
        r1_gnd  <= i_grounded;
        r1_mus  <= i_mu_static;
        r1_muk  <= i_mu_sliding;
        r2_f    <= r1_f;
        r2_nu   <= r1_nu;
        r2_n    <= n_n;
        r2_rest <= r1_rest;
        r2_gnd  <= r1_gnd;
        r2_mus  <= r1_mus;
        r2_muk  <= r1_muk;
        r3_f    <= r2_f;
        r3_q    <= n_q;
        r3_n    <= r2_n;
        r3_rest <= r2_rest;
        r3_gnd  <= r2_gnd;
        r3_mus  <= r2_mus;
        r3_muk  <= r2_muk;
    end

    // tangential part and classification
    always_comb begin
        m_nz = 1'b0;
        for (int i = 0; i < 3; i++) begin
            m_full[i] = $signed({{(PW-FW){r3_f[i][FW-1]}}, r3_f[i]}) - (r3_q[i] >>> 16);
            if (m_full[i] != '0) begin
                m_nz = 1'b1;
            end
            o_item.m[i] = sat_vec(m_full[i][63:0]);
        end
        o_item.f  = r3_f;
        o_item.n  = r3_n;
        o_item.mu = r3_rest ? r3_mus : r3_muk;
        if (r3_gnd && m_nz) begin
            o_item.mode = r3_rest ? MODE_STATIC : MODE_SLIDING;
        end else begin
            o_item.mode = MODE_NONE;
        end
        o_push = r3_v;
    end

endmodule

/* hdl/cff_queue.sv */
module cff_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cff_pkg::t_item   i_item,
    input  logic             i_pop,
    output logic             o_valid,
    output cff_pkg::t_item   o_item,
    output logic             o_full
);
    import cff_pkg::*;

    t_item r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_item  = r_mem[r_rp];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("word pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

/* hdl/cff_back.sv */
module cff_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cff_pkg::t_item   i_item,
    output logic             o_valid,
    output cff_pkg::t_vec3   o_force,
    output cff_pkg::t_mode   o_mode
);
    import cff_pkg::*;

    // squares and raw friction magnitude
    logic                  r0_v;
    t_vec3                 r0_f, r0_m;
    t_mode                 r0_mode;
    logic [63:0]           r0_sq [3];
    logic signed [MRW-1:0] r0_mr;
    logic signed [63:0]    n_sq [3];
    logic signed [MRW-1:0] n_mr;

    // square root pipeline
    logic        r_sv [SQ_STEPS+1];
    logic [63:0] r_sx [SQ_STEPS+1];
    logic [63:0] r_sr [SQ_STEPS+1];
    t_sq_pay     r_sp [SQ_STEPS+1];
    logic [63:0] n_sx [SQ_STEPS];
    logic [63:0] n_sr [SQ_STEPS];

    // divide pipeline
    logic            r_dv [QW+1];
    logic [REMW-1:0] r_dr [QW+1][3];
    logic [QW-1:0]   r_dq [QW+1][3];
    t_dv_pay         r_dp [QW+1];
    logic [REMW-1:0] n_dr [QW][3];
    logic [QW-1:0]   n_dq [QW][3];

    logic [LENW-1:0]       c_len;
    logic signed [MAGW:0]  c_mag;
    t_dv_pay               c_pay;
    logic [REMW-1:0]       c_rem [3];
    logic [FW-1:0]         c_abs [3];

    logic                  r_pv;
    logic signed [UMW-1:0] r_pp [3];
    t_vec3                 r_pf;
    t_mode                 r_pmode;
    logic signed [UPW-1:0] n_u [3];
    logic signed [UMW-1:0] n_pp [3];
    t_vec3                 n_res;

    logic  r_ov;
    t_vec3 r_of;
    t_mode r_om;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = $signed(i_item.m[i]) * $signed(i_item.m[i]);
        end
        n_mr = $signed({1'b0, i_item.mu}) * $signed(i_item.n);
    end

    always_comb begin
        logic [63:0] bit_v;
        logic [63:0] trial;
        for (int k = 0; k < SQ_STEPS; k++) begin
            bit_v = 64'd1 << (62 - 2 * k);
            trial = r_sr[k] + bit_v;
            if (r_sx[k] >= trial) begin
                n_sx[k] = r_sx[k] - trial;
                n_sr[k] = (r_sr[k] >> 1) + bit_v;
            end else begin
                n_sx[k] = r_sx[k];
                n_sr[k] = r_sr[k] >> 1;
            end
        end
    end

    // length, clamp and divider setup
    always_comb begin
        c_len = r_sr[SQ_STEPS][LENW-1:0];
        if (c_len == '0) begin
            c_len = LENW'(1);
        end
        c_mag = $signed({r_sp[SQ_STEPS].mag[MAGW-1], r_sp[SQ_STEPS].mag});
        if (r_sp[SQ_STEPS].mode == MODE_STATIC &&
            c_mag > $signed({{(MAGW+1-LENW){1'b0}}, c_len})) begin
            c_mag = $signed({{(MAGW+1-LENW){1'b0}}, c_len});
        end
        c_pay.f    = r_sp[SQ_STEPS].f;
        c_pay.len  = c_len;
        c_pay.mag  = sat_vec(64'(c_mag));
        c_pay.mode = r_sp[SQ_STEPS].mode;
        for (int i = 0; i < 3; i++) begin
            c_pay.neg[i] = r_sp[SQ_STEPS].m[i][FW-1];
            c_abs[i] = c_pay.neg[i] ? FW'(-$signed(r_sp[SQ_STEPS].m[i]))
                                    : r_sp[SQ_STEPS].m[i];
            c_rem[i] = {c_abs[i], 16'd0};
        end
    end

    always_comb begin
        logic [DW-1:0] dsr;
        for (int k = 0; k < QW; k++) begin
            dsr = {{(DW-LENW){1'b0}}, r_dp[k].len} << (QW - 1 - k);
            for (int i = 0; i < 3; i++) begin
                n_dq[k][i] = r_dq[k][i];
                if ({2'b00, r_dr[k][i]} >= dsr) begin
                    n_dr[k][i] = r_dr[k][i] - dsr[REMW-1:0];
                    n_dq[k][i][QW-1-k] = 1'b1;
                end else begin
                    n_dr[k][i] = r_dr[k][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u[i] = $signed({1'b0, r_dq[QW][i]});
            if (r_dp[QW].neg[i]) begin
                n_u[i] = -n_u[i];
            end
            n_pp[i] = n_u[i] * r_dp[QW].mag;
        end
    end

    always_comb begin
        logic signed [UMW-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            sh = r_pp[i] >>> 16;
            if (r_pmode == MODE_NONE) begin
                n_res[i] = sat_vec(64'($signed(r_pf[i])));
            end else begin
                n_res[i] = sat_vec(64'($signed(r_pf[i])) - 64'(sh));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) begin
                r_sv[k] <= 1'b0;
            end
            for (int k = 0; k <= QW; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r0_v    <= i_valid;
            r_sv[0] <= r0_v;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
            r_dv[0] <= r_sv[SQ_STEPS];
            for (int k = 0; k < QW; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_pv <= r_dv[QW];
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_f    <= i_item.f;
        r0_m    <= i_item.m;
        r0_mode <= i_item.mode;
        for (int i = 0; i < 3; i++) begin
            r0_sq[i] <= n_sq[i];
        end
        r0_mr <= n_mr;

        r_sx[0]      <= r0_sq[0] + r0_sq[1] + r0_sq[2];
        r_sr[0]      <= '0;
        r_sp[0].f    <= r0_f;
        r_sp[0].m    <= r0_m;
        r_sp[0].mag  <= MAGW'(r0_mr >>> 12);
        r_sp[0].mode <= r0_mode;
        for (int k = 0; k < SQ_STEPS; k++) begin
            r_sx[k+1] <= n_sx[k];
            r_sr[k+1] <= n_sr[k];
            r_sp[k+1] <= r_sp[k];
        end

        r_dp[0] <= c_pay;
        for (int i = 0; i < 3; i++) begin
            r_dr[0][i] <= c_rem[i];
            r_dq[0][i] <= '0;
        end
        for (int k = 0; k < QW; k++) begin
            r_dp[k+1] <= r_dp[k];
            for (int i = 0; i < 3; i++) begin
                r_dr[k+1][i] <= n_dr[k][i];
                r_dq[k+1][i] <= n_dq[k][i];
            end
        end

        r_pp    <= n_pp;
        r_pf    <= r_dp[QW].f;
        r_pmode <= r_dp[QW].mode;

        r_of <= n_res;
        r_om <= r_pmode;
    end

    assign o_valid = r_ov;
    assign o_force = r_of;
    assign o_mode  = r_om;

`ifndef NO_ASSERTIONS
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv[SQ_STEPS] |-> r_sx[SQ_STEPS] <= (r_sr[SQ_STEPS] << 1))
        else $error("square root remainder too large");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[QW] |-> (r_dr[QW][0] < REMW'(r_dp[QW].len)) &&
                     (r_dr[QW][1] < REMW'(r_dp[QW].len)) &&
                     (r_dr[QW][2] < REMW'(r_dp[QW].len)))
        else $error("divider remainder not below length");
`endif

endmodule

/* hdl/coulomb_friction_force_unit.sv */
// throughput: one word per cycle, set by the fully pipelined square root and dividers
// the back pipeline never stalls, so the front queue does not fill and busy stays low
// reset: synchronous active-low i_rst_n clears all valid flags and the queue
// results appear once for one cycle on o_valid; the receiver cannot stall
module coulomb_friction_force_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_force_x,
    input  logic [31:0] i_force_y,
    input  logic [31:0] i_force_z,
    input  logic [31:0] i_up_x,
    input  logic [31:0] i_up_y,
    input  logic [31:0] i_up_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    input  logic [15:0] i_mu_static,
    input  logic [15:0] i_mu_sliding,
    input  logic        i_grounded,
    output logic        o_valid,
    output logic [31:0] o_out_force_x,
    output logic [31:0] o_out_force_y,
    output logic [31:0] o_out_force_z,
    output logic [1:0]  o_friction_mode
);
    import cff_pkg::*;

    t_vec3 force_v, up_v, vel_v, res_v;
    t_item push_item, head_item;
    t_mode res_mode;
    logic  accept, push, head_valid, full;

    assign force_v = {i_force_z, i_force_y, i_force_x};
    assign up_v    = {i_up_z, i_up_y, i_up_x};
    assign vel_v   = {i_vel_z, i_vel_y, i_vel_x};
    assign busy    = full;
    assign accept  = start && !busy;

    cff_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_force      (force_v),
        .i_up         (up_v),
        .i_vel        (vel_v),
        .i_mu_static  (i_mu_static),
        .i_mu_sliding (i_mu_sliding),
        .i_grounded   (i_grounded),
        .o_push       (push),
        .o_item       (push_item)
    );

    cff_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (head_valid),
        .o_valid (head_valid),
        .o_item  (head_item),
        .o_full  (full)
    );

    cff_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_item  (head_item),
        .o_valid (o_valid),
        .o_force (res_v),
        .o_mode  (res_mode)
    );

    assign o_out_force_x   = res_v[0];
    assign o_out_force_y   = res_v[1];
    assign o_out_force_z   = res_v[2];
    assign o_friction_mode = res_mode;

endmodule

/* sim/friction_checker.sv */
module friction_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_force_x,
    input  logic [31:0] i_force_y,
    input  logic [31:0] i_force_z,
    input  logic [31:0] i_up_x,
    input  logic [31:0] i_up_y,
    input  logic [31:0] i_up_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    input  logic [15:0] i_mu_static,
    input  logic [15:0] i_mu_sliding,
    input  logic        i_grounded,
    input  logic        o_valid,
    input  logic [31:0] o_out_force_x,
    input  logic [31:0] o_out_force_y,
    input  logic [31:0] o_out_force_z,
    input  logic [1:0]  o_friction_mode,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_static_cnt,
    output int          o_sliding_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    import cff_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        t_mode       mode;
    } t_force_word;

    t_force_word force_q[$];

    function automatic longint clamp_vec(input longint x);
        if (x > longint'(SAT_HI)) return longint'(SAT_HI);
        if (x < longint'(SAT_LO)) return longint'(SAT_LO);
        return x;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_force_word apply_friction(
        input logic [2:0][31:0] fv, input logic [2:0][31:0] uv, input logic [2:0][31:0] vv,
        input logic [15:0] mus, input logic [15:0] muk, input logic gnd);
        t_force_word w;
        longint f[3];
        longint nu[3];
        longint m[3];
        longint res[3];
        longint n;
        longint mag;
        longint u;
        longint unsigned sq;
        longint unsigned len;
        bit rest;
        t_mode mode;
        mode = MODE_NONE;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            f[i] = longint'($signed(fv[i]));
            nu[i] = -longint'($signed(uv[i]));
            res[i] = f[i];
        end
        rest = (vv[0] == 0) && (vv[1] == 0) && (vv[2] == 0);
        if (gnd) begin
            n = 0;
            for (int i = 0; i < 3; i++) n += (f[i] * nu[i]) >>> 16;
            n = clamp_vec(n);
            for (int i = 0; i < 3; i++) m[i] = f[i] - ((nu[i] * n) >>> 16);
            if (m[0] != 0 || m[1] != 0 || m[2] != 0) begin
                for (int i = 0; i < 3; i++) begin
                    m[i] = clamp_vec(m[i]);
                    sq += longint'(unsigned'(m[i] * m[i]));
                end
                len = floor_sqrt(sq);
                if (len == 0) len = 1;
                if (rest) begin
                    mag = (longint'({48'd0, mus}) * n) >>> 12;
                    if (mag > longint'(len)) mag = longint'(len);
                    mode = MODE_STATIC;
                end else begin
                    mag = (longint'({48'd0, muk}) * n) >>> 12;
                    mode = MODE_SLIDING;
                end
                mag = clamp_vec(mag);
                for (int i = 0; i < 3; i++) begin
                    u = (m[i] * 65536) / longint'(len);
                    res[i] = f[i] - ((u * mag) >>> 16);
                end
            end
        end
        w.x = 32'(clamp_vec(res[0]));
        w.y = 32'(clamp_vec(res[1]));
        w.z = 32'(clamp_vec(res[2]));
        w.mode = mode;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_checked = 0;
        o_static_cnt = 0;
        o_sliding_cnt = 0;
    end

    always @(posedge i_clk) begin
        t_force_word want;
        if (i_rst_n) begin
            if (start && !busy) begin
                force_q.push_back(apply_friction({i_force_z, i_force_y, i_force_x},
                    {i_up_z, i_up_y, i_up_x}, {i_vel_z, i_vel_y, i_vel_x},
                    i_mu_static, i_mu_sliding, i_grounded));
            end
            if (o_valid) begin
                if (force_q.size() == 0) begin
                    report_mismatch("unexpected word", 32'(o_friction_mode), 32'd0);
                end else begin
                    want = force_q.pop_front();
                    o_checked++;
                    if (want.mode == MODE_STATIC) o_static_cnt++;
                    if (want.mode == MODE_SLIDING) o_sliding_cnt++;
                    if (o_out_force_x !== want.x)
                        report_mismatch("force_x", o_out_force_x, want.x);
                    if (o_out_force_y !== want.y)
                        report_mismatch("force_y", o_out_force_y, want.y);
                    if (o_out_force_z !== want.z)
                        report_mismatch("force_z", o_out_force_z, want.z);
                    if (o_friction_mode !== want.mode)
                        report_mismatch("mode", 32'(o_friction_mode), 32'(want.mode));
                end
            end
        end
        o_pending = force_q.size();
    end

endmodule

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1500;
    localparam int N_CALM     = 200;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 80;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_force_x = '0, i_force_y = '0, i_force_z = '0;
    logic [31:0] i_up_x = '0, i_up_y = '0, i_up_z = '0;
    logic [31:0] i_vel_x = '0, i_vel_y = '0, i_vel_z = '0;
    logic [15:0] i_mu_static = '0, i_mu_sliding = '0;
    logic        i_grounded = 1'b0;
    logic        o_valid;
    logic [31:0] o_out_force_x, o_out_force_y, o_out_force_z;
    logic [1:0]  o_friction_mode;
    int          errors, pending, checked, static_cnt, sliding_cnt;
    int          idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    coulomb_friction_force_unit u_top (.*);

    friction_checker u_chk (
        .*,
        .o_errors(errors),
        .o_pending(pending),
        .o_checked(checked),
        .o_static_cnt(static_cnt),
        .o_sliding_cnt(sliding_cnt)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("FAIL coulomb_friction_force_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // word is presented at a rising edge, held until accepted
    task automatic send_word(input logic [31:0] fx, fy, fz, ux, uy, uz, vx, vy, vz,
                             input logic [15:0] mus, muk, input logic gnd);
        i_force_x <= fx; i_force_y <= fy; i_force_z <= fz;
        i_up_x <= ux; i_up_y <= uy; i_up_z <= uz;
        i_vel_x <= vx; i_vel_y <= vy; i_vel_z <= vz;
        i_mu_static <= mus; i_mu_sliding <= muk;
        i_grounded <= gnd;
        start <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
    endtask

    task automatic idle_gap(input bit calm);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_small();
        return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endfunction

    task automatic send_random(input bit calm);
        logic [31:0] f[3], u[3], v[3];
        logic [15:0] mus, muk;
        int axis;
        for (int i = 0; i < 3; i++) begin
            f[i] = ($urandom_range(0, 4) == 0) ? $urandom() : rand_small();
            v[i] = 32'd0;
        end
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                axis = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++) u[i] = 32'd0;
                u[axis] = $urandom_range(0, 1) ? ONE : -ONE;
            end
            3, 4: for (int i = 0; i < 3; i++) u[i] = 32'($urandom_range(0, 2 * ONE)) - ONE;
            default: for (int i = 0; i < 3; i++) u[i] = $urandom();
        endcase
        case ($urandom_range(0, 3))
            0: ;
            1: v[$urandom_range(0, 2)] = $urandom();
            default: for (int i = 0; i < 3; i++) v[i] = $urandom();
        endcase
        mus = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h2000)) : 16'($urandom());
        muk = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h2000)) : 16'($urandom());
        send_word(f[0], f[1], f[2], u[0], u[1], u[2], v[0], v[1], v[2], mus, muk,
                  $urandom_range(0, 7) != 0);
        idle_gap(calm);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // airborne, extremes pass through
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, ONE, 32'd0,
                  '0, '0, '0, 16'hFFFF, 16'hFFFF, 1'b0);
        // force along up only, no tangential part
        send_word(32'd0, -32'd5 * ONE, 32'd0, 32'd0, ONE, 32'd0,
                  '0, '0, '0, 16'h1000, 16'h1000, 1'b1);
        // resting, friction below tangential force
        send_word(ONE, -32'd10 * ONE, 32'd0, 32'd0, ONE, 32'd0,
                  '0, '0, '0, 16'h0040, 16'h1000, 1'b1);
        // resting, static friction clamped to tangential magnitude
        send_word(ONE, -32'd10 * ONE, ONE, 32'd0, ONE, 32'd0,
                  '0, '0, '0, 16'hFFFF, 16'h0000, 1'b1);
        // sliding, each velocity component alone
        send_word(3 * ONE, -ONE, -2 * ONE, 32'd0, ONE, 32'd0,
                  32'd1, '0, '0, 16'h0000, 16'h0800, 1'b1);
        send_word(3 * ONE, -ONE, -2 * ONE, 32'd0, ONE, 32'd0,
                  '0, 32'h8000_0000, '0, 16'h0000, 16'hFFFF, 1'b1);
        send_word(3 * ONE, -ONE, -2 * ONE, 32'd0, ONE, 32'd0,
                  '0, '0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1'b1);
        // negative normal force
        send_word(ONE, 4 * ONE, 0, 32'd0, ONE, 32'd0,
                  '0, '0, '0, 16'h1000, 16'h1000, 1'b1);
        send_word(ONE, 4 * ONE, 0, 32'd0, ONE, 32'd0,
                  32'd7, '0, '0, 16'h1000, 16'h2000, 1'b1);
        // up vectors along the negative x and negative z axes
        send_word(2 * ONE, 2 * ONE, 2 * ONE, -ONE, 32'd0, 32'd0,
                  '0, '0, '0, 16'h0800, 16'h0400, 1'b1);
        send_word(2 * ONE, 2 * ONE, 2 * ONE, 32'd0, 32'd0, -ONE,
                  '0, ONE, '0, 16'h0800, 16'h0400, 1'b1);
        // saturation corners
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0, '0,
                  16'hFFFF, 16'hFFFF, 1'b1);
        send_word(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, ONE, 32'd0, 32'd0,
                  '0, '0, '0, 16'hFFFF, 16'h8000, 1'b1);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);

        for (int k = 0; k < N_RANDOM; k++) send_random(k >= N_RANDOM - N_CALM);
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("checked %0d words: %0d static, %0d sliding, rest passed through",
                 checked, static_cnt, sliding_cnt);
        $display("directed corners plus %0d random words with random start gaps",
                 N_RANDOM);
        if (errors == 0) begin
            $display("PASS coulomb_friction_force_unit");
        end else begin
            $display("FAIL coulomb_friction_force_unit");
        end
        $finish;
    end

endmodule
